// ===== sv/prts_pkg.sv =====
// prts_pkg: shared constants, types and helpers of the job scheduler
// used by the channel interfaces, the job table and the top level
`timescale 1ns / 1ps

package prts_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int SLOT_IN_W  = 4;
    localparam int BURST_W    = 16;
    localparam int PRIO_W     = 5;
    localparam int KEY_W      = 16;
    localparam int WAIT_W     = 20;
    localparam int TURN_W     = 21;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    typedef enum logic [0:0] {
        CMD_ARRIVE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_TAKEN  = 3'd0,
        ST_REJECT = 3'd1,
        ST_RAN    = 3'd2,
        ST_IDLE   = 3'd3,
        ST_DONE   = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREEMPT = 2'd0,
        CFG_ORDER   = 2'd1
    } t_cfg_idx;

    // one job slot as held in the table
    typedef struct packed {
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [WAIT_W-1:0]  waited;
    } t_entry;

    // table access for one cycle: one write port, one read port
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic [SLOT_W-1:0] raddr;
    } t_tbl_req;

    function automatic logic [KEY_W-1:0] key_of(input t_entry e, input logic by_remaining);
        logic [KEY_W-1:0] k;
        k = by_remaining ? e.remaining : KEY_W'(e.prio);
        return k;
    endfunction

endpackage

// ===== sv/prts_if.sv =====
// prts_if: valid/ready channels of the job scheduler
// job input, result output and configuration write; uses prts_pkg widths
`timescale 1ns / 1ps

interface prts_job_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [prts_pkg::SLOT_IN_W-1:0] slot;
    logic [prts_pkg::BURST_W-1:0]   burst;
    logic [prts_pkg::PRIO_W-1:0]    prio;

    modport source (output valid, cmd, slot, burst, prio, input ready);
    modport sink   (input valid, cmd, slot, burst, prio, output ready);
endinterface

interface prts_res_if;
    logic                           valid;
    logic                           ready;
    logic [prts_pkg::STATUS_W-1:0]  status;
    logic [prts_pkg::SLOT_IN_W-1:0] job_slot;
    logic [prts_pkg::WAIT_W-1:0]    wait_ticks;
    logic [prts_pkg::TURN_W-1:0]    turnaround;

    modport source (output valid, status, job_slot, wait_ticks, turnaround, input ready);
    modport sink   (input valid, status, job_slot, wait_ticks, turnaround, output ready);
endinterface

interface prts_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [prts_pkg::CFG_IDX_W-1:0] index;
    logic                           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/prts_table.sv =====
// prts_table: job slot table, one write port and one registered read port
// depends on prts_pkg for the entry and request types
`timescale 1ns / 1ps

module prts_table (
    input  logic               i_clk,
    input  prts_pkg::t_tbl_req i_req,
    output prts_pkg::t_entry   o_rd
);
    import prts_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd <= r_mem[i_req.raddr];
    end

    assign o_rd = r_rd;

endmodule

// ===== sv/priority_or_remaining_time_scheduler.sv =====
// priority_or_remaining_time_scheduler: tick-driven preemptive priority / srtf scheduler
// depends on prts_pkg, prts_if (channels) and prts_table (slot storage)
//
//   channel   dir   payload                                      purpose
//   i_job     in    cmd, slot, burst, prio                       arrival or tick
//   o_res     out   status, job_slot, wait_ticks, turnaround     one result per item
//   i_cfg     in    index, data                                  register write
//
// an arrival has its result registered as it is taken; a tick makes one pass over the
// table to find the smallest key and, if a slot is valid, one pass to update
// remaining and waiting times, both through the single table read port.
// i_job.ready is high only while the sequencer is idle, from the cycle after a result
// is registered; a result held in the output register stalls the result step.
// reset is synchronous: no slot valid, no running job, preemptive=1, order=0.
// configuration writes are always taken.
`timescale 1ns / 1ps

module priority_or_remaining_time_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prts_job_if.sink   i_job,
    prts_res_if.source o_res,
    prts_cfg_if.sink   i_cfg
);
    import prts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_UPDATE = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_rd_v, n_rd_v;
    logic [SLOT_W-1:0]    r_rd_idx, n_rd_idx;
    logic [SLOTS-1:0]     r_slot_valid, n_slot_valid;
    logic [SLOT_W-1:0]    r_run_slot, n_run_slot;
    logic                 r_run_v, n_run_v;
    logic                 r_preempt, n_preempt;
    logic                 r_order, n_order;
    logic                 r_found, n_found;
    logic [SLOT_W-1:0]    r_best, n_best;
    logic [KEY_W-1:0]     r_best_key, n_best_key;
    logic [KEY_W-1:0]     r_run_key, n_run_key;
    logic [SLOT_W-1:0]    r_pick, n_pick;
    t_status              r_res_status, n_res_status;
    logic [SLOT_IN_W-1:0] r_res_slot, n_res_slot;
    logic [WAIT_W-1:0]    r_res_wait, n_res_wait;
    logic [TURN_W-1:0]    r_res_turn, n_res_turn;
    logic                 r_out_v, n_out_v;
    t_status              r_out_status, n_out_status;
    logic [SLOT_IN_W-1:0] r_out_slot, n_out_slot;
    logic [WAIT_W-1:0]    r_out_wait, n_out_wait;
    logic [TURN_W-1:0]    r_out_turn, n_out_turn;

    t_tbl_req         tbl_req;
    t_entry           rd;
    logic             job_acc;
    logic             issuing;
    logic [SLOT_W-1:0] in_idx;
    logic             in_reject;
    logic [KEY_W-1:0] rd_key;
    logic             keep_run;
    logic             last_rd;
    logic             out_load;
    logic [BURST_W-1:0] rem_dec;

    prts_table u_table (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .o_rd  (rd)
    );

    assign i_job.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign job_acc     = i_job.valid && i_job.ready;

    assign in_idx    = SLOT_W'(i_job.slot);
    assign in_reject = (i_job.burst == '0) || !(int'(i_job.slot) < SLOTS)
                       || r_slot_valid[in_idx];

    assign issuing = ((r_state == S_SCAN) || (r_state == S_UPDATE))
                     && (r_cnt < CNT_W'(SLOTS));
    assign last_rd = r_rd_v && (r_rd_idx == SLOT_W'(SLOTS - 1));
    assign rd_key  = key_of(rd, r_order);
    assign rem_dec = rd.remaining - 1'b1;

    assign keep_run = r_run_v && r_slot_valid[r_run_slot]
                      && (!r_preempt || !(r_best_key < r_run_key));

    assign out_load = (r_state == S_RESULT) && (!r_out_v || o_res.ready);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_rd_v       = issuing;
        n_rd_idx     = r_cnt[SLOT_W-1:0];
        n_slot_valid = r_slot_valid;
        n_run_slot   = r_run_slot;
        n_run_v      = r_run_v;
        n_preempt    = r_preempt;
        n_order      = r_order;
        n_found      = r_found;
        n_best       = r_best;
        n_best_key   = r_best_key;
        n_run_key    = r_run_key;
        n_pick       = r_pick;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_wait   = r_res_wait;
        n_res_turn   = r_res_turn;
        n_out_v      = r_out_v;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_wait   = r_out_wait;
        n_out_turn   = r_out_turn;

        tbl_req       = '0;
        tbl_req.raddr = r_cnt[SLOT_W-1:0];

        if (issuing) begin
            n_cnt = r_cnt + 1'b1;
        end

        if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_PREEMPT: n_preempt = i_cfg.data;
                CFG_ORDER:   n_order   = i_cfg.data;
                default:     ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (job_acc) begin
                    n_res_slot = i_job.slot;
                    n_res_wait = '0;
                    n_res_turn = '0;
                    n_state    = S_RESULT;
                    if (i_job.cmd == CMD_TICK) begin
                        n_state = S_SCAN;
                        n_cnt   = '0;
                        n_found = 1'b0;
                    end else if (in_reject) begin
                        n_res_status = ST_REJECT;
                    end else begin
                        n_res_status            = ST_TAKEN;
                        n_slot_valid[in_idx]    = 1'b1;
                        tbl_req.we              = 1'b1;
                        tbl_req.waddr           = in_idx;
                        tbl_req.wdata.remaining = i_job.burst;
                        tbl_req.wdata.burst     = i_job.burst;
                        tbl_req.wdata.prio      = i_job.prio;
                        tbl_req.wdata.waited    = '0;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_v && r_slot_valid[r_rd_idx]) begin
                    // strict compare keeps the lowest slot on equal keys
                    if (!r_found || (rd_key < r_best_key)) begin
                        n_found    = 1'b1;
                        n_best     = r_rd_idx;
                        n_best_key = rd_key;
                    end
                    if (r_rd_idx == r_run_slot) begin
                        n_run_key = rd_key;
                    end
                end
                if (last_rd) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!r_found) begin
                    n_run_v      = 1'b0;
                    n_res_status = ST_IDLE;
                    n_res_slot   = '0;
                    n_res_wait   = '0;
                    n_res_turn   = '0;
                    n_state      = S_RESULT;
                end else begin
                    n_pick  = keep_run ? r_run_slot : r_best;
                    n_cnt   = '0;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_rd_v && r_slot_valid[r_rd_idx]) begin
                    tbl_req.we    = 1'b1;
                    tbl_req.waddr = r_rd_idx;
                    tbl_req.wdata = rd;
                    if (r_rd_idx == r_pick) begin
                        tbl_req.wdata.remaining = rem_dec;
                        n_res_slot = SLOT_IN_W'(r_pick);
                        if (rem_dec == '0) begin
                            n_slot_valid[r_rd_idx] = 1'b0;
                            n_run_v      = 1'b0;
                            n_run_slot   = '0;
                            n_res_status = ST_DONE;
                            n_res_wait   = rd.waited;
                            n_res_turn   = TURN_W'(rd.burst) + TURN_W'(rd.waited);
                        end else begin
                            n_run_v      = 1'b1;
                            n_run_slot   = r_pick;
                            n_res_status = ST_RAN;
                            n_res_wait   = '0;
                            n_res_turn   = '0;
                        end
                    end else if (rd.waited != WAIT_MAX) begin
                        tbl_req.wdata.waited = rd.waited + 1'b1;
                    end
                end
                if (last_rd) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (out_load) begin
            n_out_v      = 1'b1;
            n_out_status = r_res_status;
            n_out_slot   = r_res_slot;
            n_out_wait   = r_res_wait;
            n_out_turn   = r_res_turn;
        end else if (r_out_v && o_res.ready) begin
            n_out_v = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_rd_v       <= 1'b0;
            r_slot_valid <= '0;
            r_run_slot   <= '0;
            r_run_v      <= 1'b0;
            r_preempt    <= 1'b1;
            r_order      <= 1'b0;
            r_found      <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_rd_v       <= n_rd_v;
            r_slot_valid <= n_slot_valid;
            r_run_slot   <= n_run_slot;
            r_run_v      <= n_run_v;
            r_preempt    <= n_preempt;
            r_order      <= n_order;
            r_found      <= n_found;
            r_out_v      <= n_out_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_best       <= n_best;
        r_best_key   <= n_best_key;
        r_run_key    <= n_run_key;
        r_pick       <= n_pick;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_wait   <= n_res_wait;
        r_res_turn   <= n_res_turn;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_wait   <= n_out_wait;
        r_out_turn   <= n_out_turn;
    end

    assign o_res.valid      = r_out_v;
    assign o_res.status     = r_out_status;
    assign o_res.job_slot   = r_out_slot;
    assign o_res.wait_ticks = r_out_wait;
    assign o_res.turnaround = r_out_turn;

    a_out_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state == S_RESULT))
        else $error("result valid rose outside the result step");

    a_running_is_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_v |-> r_slot_valid[r_run_slot])
        else $error("running job points at a free slot");

    a_slot_fill_by_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_slot_valid) > $countones($past(r_slot_valid)))
        |-> $past(job_acc && (i_job.cmd == CMD_ARRIVE)))
        else $error("slot filled without an arrival transaction");

    a_scan_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_state == S_SCAN) || (r_state == S_DECIDE))
        else $error("scan pass left early");

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for priority_or_remaining_time_scheduler
// depends on prts_pkg, the prts_*_if channels and the scheduler top level
`timescale 1ns / 1ps

module tb_top;
    import prts_pkg::*;

    typedef struct {
        t_cmd                 cmd;
        logic [SLOT_IN_W-1:0] slot;
        logic [BURST_W-1:0]   burst;
        logic [PRIO_W-1:0]    prio;
        int unsigned          gap;
    } t_job_req;

    typedef struct {
        t_status              status;
        logic [SLOT_IN_W-1:0] job_slot;
        logic [WAIT_W-1:0]    wait_ticks;
        logic [TURN_W-1:0]    turnaround;
    } t_outcome;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 2 * SLOTS + 8;
    localparam int PHASE_ITEMS    = 120;
    localparam int PHASES         = 6;

    logic i_clk;
    logic i_rst_n;

    prts_job_if job_ch ();
    prts_res_if res_ch ();
    prts_cfg_if cfg_ch ();

    priority_or_remaining_time_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // scheduler state as the bench tracks it
    bit                 occupied  [SLOTS];
    logic [BURST_W-1:0] remain    [SLOTS];
    logic [BURST_W-1:0] burst_len [SLOTS];
    logic [PRIO_W-1:0]  prio_val  [SLOTS];
    logic [WAIT_W-1:0]  waited    [SLOTS];
    int                 run_slot     = 0;
    bit                 run_valid    = 1'b0;
    logic               preempt_on   = 1'b1;
    logic               by_remaining = 1'b0;

    t_job_req    job_backlog[$];
    t_outcome    awaited_outcomes[$];
    t_job_req    tx_staged;
    bit          tx_have;
    int unsigned tx_gap;
    int          tx_fast_left = 0;
    int unsigned rx_wait;
    int          rx_fast_left = 0;
    int unsigned rx_stall_left;
    logic        rx_stall_start;

    int n_fail     = 0;
    int n_accepted = 0;
    int n_settings = 0;
    int n_status [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [KEY_W-1:0] job_key(int s);
        return by_remaining ? remain[s] : KEY_W'(prio_val[s]);
    endfunction

    // advance the tracked scheduler by one transaction and return its outcome
    function automatic t_outcome schedule_item(t_job_req j);
        t_outcome          r;
        int                pick;
        bit                found;
        logic [WAIT_W-1:0] w;
        r.status     = ST_TAKEN;
        r.job_slot   = j.slot;
        r.wait_ticks = '0;
        r.turnaround = '0;
        if (j.cmd == CMD_ARRIVE) begin
            if (j.burst == '0 || int'(j.slot) >= SLOTS || occupied[j.slot]) begin
                r.status = ST_REJECT;
            end else begin
                occupied[j.slot]  = 1'b1;
                remain[j.slot]    = j.burst;
                burst_len[j.slot] = j.burst;
                prio_val[j.slot]  = j.prio;
                waited[j.slot]    = '0;
            end
            return r;
        end
        found = 1'b0;
        pick  = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if (occupied[s] && (!found || job_key(s) < job_key(pick))) begin
                pick  = s;
                found = 1'b1;
            end
        end
        if (!found) begin
            run_valid  = 1'b0;
            r.status   = ST_IDLE;
            r.job_slot = '0;
            return r;
        end
        // running job stays on a tie, and always when preemption is off
        if (run_valid && occupied[run_slot]) begin
            if (!preempt_on || !(job_key(pick) < job_key(run_slot)))
                pick = run_slot;
        end
        remain[pick] = remain[pick] - 1'b1;
        for (int s = 0; s < SLOTS; s++) begin
            if (occupied[s] && s != pick && waited[s] != WAIT_MAX)
                waited[s] = waited[s] + 1'b1;
        end
        r.job_slot = SLOT_IN_W'(pick);
        if (remain[pick] == '0) begin
            w              = waited[pick];
            occupied[pick] = 1'b0;
            run_valid      = 1'b0;
            run_slot       = 0;
            r.status       = ST_DONE;
            r.wait_ticks   = w;
            r.turnaround   = TURN_W'(burst_len[pick]) + TURN_W'(w);
        end else begin
            run_slot  = pick;
            run_valid = 1'b1;
            r.status  = ST_RAN;
        end
        return r;
    endfunction

    function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    task automatic offer_job(t_job_req r);
        job_ch.valid <= 1'b1;
        job_ch.cmd   <= r.cmd;
        job_ch.slot  <= r.slot;
        job_ch.burst <= r.burst;
        job_ch.prio  <= r.prio;
    endtask

    always @(posedge i_clk) begin : job_driver
        t_job_req took;
        t_job_req nxt;
        if (!i_rst_n) begin
            job_ch.valid <= 1'b0;
            tx_have      <= 1'b0;
            tx_gap       <= 0;
        end else begin
            if (job_ch.valid && job_ch.ready) begin
                took.cmd   = t_cmd'(job_ch.cmd);
                took.slot  = job_ch.slot;
                took.burst = job_ch.burst;
                took.prio  = job_ch.prio;
                took.gap   = 0;
                awaited_outcomes.insert(awaited_outcomes.size(), schedule_item(took));
                n_accepted++;
            end
            if (job_ch.valid && !job_ch.ready) begin
                // offer stands until taken
            end else if (tx_have) begin
                if (tx_gap == 0) begin
                    offer_job(tx_staged);
                    tx_have <= 1'b0;
                end else begin
                    tx_gap       <= tx_gap - 1;
                    job_ch.valid <= 1'b0;
                end
            end else if (job_backlog.size() != 0) begin
                nxt = job_backlog.pop_front();
                if (nxt.gap == 0) begin
                    offer_job(nxt);
                end else begin
                    tx_staged    <= nxt;
                    tx_have      <= 1'b1;
                    tx_gap       <= nxt.gap - 1;
                    job_ch.valid <= 1'b0;
                end
            end else begin
                job_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : rx_hold
        if (!i_rst_n)
            rx_stall_left <= 0;
        else if (rx_stall_start)
            rx_stall_left <= RX_HOLD_CYCLES;
        else if (rx_stall_left != 0)
            rx_stall_left <= rx_stall_left - 1;
    end

    always @(posedge i_clk) begin : result_monitor
        t_outcome    want;
        int unsigned nxt_wait;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rx_wait      <= 0;
        end else begin
            nxt_wait = rx_wait;
            if (res_ch.valid && res_ch.ready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result with nothing outstanding: status %0d, job_slot %0d",
                           res_ch.status, res_ch.job_slot);
                    n_fail++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    match_field("status", want.status, res_ch.status);
                    match_field("job_slot", want.job_slot, res_ch.job_slot);
                    match_field("wait_ticks", want.wait_ticks, res_ch.wait_ticks);
                    match_field("turnaround", want.turnaround, res_ch.turnaround);
                    n_status[want.status]++;
                end
                if (rx_fast_left > 0) begin
                    rx_fast_left--;
                    nxt_wait = 0;
                end else begin
                    nxt_wait = $urandom_range(0, 11);
                    if ($urandom_range(0, 15) == 0)
                        rx_fast_left = $urandom_range(8, 40);
                end
            end else if (res_ch.valid && rx_wait != 0) begin
                nxt_wait = rx_wait - 1;
            end
            rx_wait      <= nxt_wait;
            res_ch.ready <= (nxt_wait == 0) && (rx_stall_left == 0);
        end
    end

    task automatic push_job(t_cmd c, int s, int b, int p);
        t_job_req r;
        r.cmd   = c;
        r.slot  = SLOT_IN_W'(s);
        r.burst = BURST_W'(b);
        r.prio  = PRIO_W'(p);
        if (tx_fast_left > 0) begin
            tx_fast_left--;
            r.gap = 0;
        end else begin
            r.gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0)
                tx_fast_left = $urandom_range(8, 40);
        end
        job_backlog.insert(job_backlog.size(), r);
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        while (job_backlog.size() != 0 || tx_have || job_ch.valid
               || awaited_outcomes.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic d);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_PREEMPT: preempt_on   = d;
            CFG_ORDER:   by_remaining = d;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic pre, logic ord);
        write_reg(CFG_PREEMPT, pre);
        write_reg(CFG_ORDER, ord);
        n_settings++;
    endtask

    // run every queued job to completion, then one idle tick
    task automatic drain_table();
        int total;
        total = 1;
        for (int s = 0; s < SLOTS; s++)
            if (occupied[s]) total += remain[s];
        repeat (total) push_job(CMD_TICK, 0, 0, 0);
        wait_quiet();
    endtask

    task automatic push_random(int n);
        int sel;
        int s;
        int b;
        int p;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            s   = $urandom_range(0, SLOTS - 1);
            p   = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31);
            b   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            if (sel < 25) begin
                push_job(CMD_ARRIVE, s, b, p);
            end else if (sel < 87) begin
                if ($urandom_range(0, 1))
                    push_job(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 65535),
                             $urandom_range(0, 31));
                else
                    push_job(CMD_TICK, 0, 0, 0);
            end else if (sel < 93) begin
                push_job(CMD_ARRIVE, s, 0, p);
            end else begin
                // second arrival hits a slot that is surely occupied
                push_job(CMD_ARRIVE, s, b, p);
                push_job(CMD_ARRIVE, s, $urandom_range(0, 65535), $urandom_range(0, 31));
                i++;
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n        = 1'b0;
        job_ch.valid   = 1'b0;
        job_ch.cmd     = CMD_ARRIVE;
        job_ch.slot    = '0;
        job_ch.burst   = '0;
        job_ch.prio    = '0;
        res_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_PREEMPT;
        cfg_ch.data    = 1'b0;
        rx_stall_start = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under reset settings: preemptive, ordered by priority
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_ARRIVE, 0, 0, 5);
        push_job(CMD_ARRIVE, 0, 3, 31);
        push_job(CMD_ARRIVE, 0, 5, 0);
        push_job(CMD_ARRIVE, SLOTS - 1, 2, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_ARRIVE, 3, 1, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_ARRIVE, 7, 2, 10);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 15, 16'hFFFF, 31);
        push_job(CMD_ARRIVE, 8, 1, 31);
        push_job(CMD_ARRIVE, 8, 16'hFFFF, 31);
        push_job(CMD_ARRIVE, 9, 1, 31);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 0, 0, 0);
        wait_quiet();
        drain_table();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_settings(1'b1, 1'b0);
                1: apply_settings(1'b0, 1'b0);
                2: apply_settings(1'b1, 1'b1);
                3: apply_settings(1'b0, 1'b1);
                default: apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            if (ph == 1) begin
                write_reg(CFG_SPARE_LO, 1'b1);
                write_reg(CFG_SPARE_HI, 1'b1);
            end
            push_random(PHASE_ITEMS);
            if (ph == 2) begin
                // receiver holds off while the sender keeps offering
                @(posedge i_clk);
                rx_stall_start <= 1'b1;
                @(posedge i_clk);
                rx_stall_start <= 1'b0;
            end
            wait_quiet();
            drain_table();
        end

        // longest burst last: it never completes within the run
        push_job(CMD_ARRIVE, SLOTS - 1, 16'hFFFF, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_ARRIVE, 0, 1, 31);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 0, 0, 0);
        push_job(CMD_TICK, 0, 0, 0);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions across %0d register settings",
                 n_accepted, n_settings);
        $display("outcomes: %0d taken, %0d rejected, %0d ran, %0d finished, %0d idle",
                 n_status[ST_TAKEN], n_status[ST_REJECT], n_status[ST_RAN],
                 n_status[ST_DONE], n_status[ST_IDLE]);
        if (n_fail == 0 && awaited_outcomes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/prts_pkg.sv
sv/prts_if.sv
sv/prts_table.sv
sv/priority_or_remaining_time_scheduler.sv
bench/tb_top.sv
